// File: sv/anx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anx_pkg
// shared widths, nal type and status codes, and the result and push types
// of the annex b nal unit scanner
// ----------------------------------------------------------------------------
package anx_pkg;

    localparam int OFFSET_BITS  = 32;
    localparam int LEN_BITS     = 16;
    localparam int COUNT_BITS   = 32;
    localparam int TYPE_BITS    = 5;
    localparam int PROFILE_BITS = 24;
    localparam int STATUS_BITS  = 2;
    localparam int MATCH_BITS   = 3;
    localparam int CAP_BITS     = 2;

    // start code 00 00 00 01 is four bytes long
    localparam logic [MATCH_BITS-1:0] SC_LEN = 3'd4;
    localparam logic [CAP_BITS-1:0]   SPS_CAPTURE_BYTES = 2'd3;

    localparam logic [TYPE_BITS-1:0] NAL_IDR = 5'd5;
    localparam logic [TYPE_BITS-1:0] NAL_SPS = 5'd7;
    localparam logic [TYPE_BITS-1:0] NAL_PPS = 5'd8;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUP_SPS = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_DUP_PPS = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd3;

    // result queue
    localparam int QUEUE_DEPTH = 3;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [OFFSET_BITS-1:0]  nal_offset;
        logic [OFFSET_BITS-1:0]  nal_size;
        logic [TYPE_BITS-1:0]    nal_kind;
        logic [COUNT_BITS-1:0]   sample_index;
        logic [STATUS_BITS-1:0]  status;
        logic [COUNT_BITS-1:0]   picture_count;
        logic [COUNT_BITS-1:0]   sync_count;
        logic [LEN_BITS-1:0]     sps_size;
        logic [LEN_BITS-1:0]     pps_size;
        logic [PROFILE_BITS-1:0] profile_level;
        logic                    record_valid;
        logic                    last;
    } anx_result_t;

    // up to two results come out of one item
    typedef struct packed {
        logic [1:0]  count;
        anx_result_t first;
        anx_result_t second;
    } anx_push_t;

    function automatic logic [LEN_BITS-1:0] sat_len(input logic [OFFSET_BITS-1:0] size);
        logic [LEN_BITS-1:0] r;
        if (size > OFFSET_BITS'({LEN_BITS{1'b1}}))
        begin
            r = {LEN_BITS{1'b1}};
        end
        else
        begin
            r = size[LEN_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// File: sv/anx_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anx_scan_core
// start code matcher, nal unit bookkeeping and parameter set capture;
// one item is processed per accepted byte
// ----------------------------------------------------------------------------
module anx_scan_core
    import anx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output anx_push_t  push
);

    logic [MATCH_BITS-1:0]   match_reg, match_next;
    logic [OFFSET_BITS-1:0]  pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]  open_off_reg, open_off_next;
    logic [TYPE_BITS-1:0]    open_type_reg, open_type_next;
    logic [COUNT_BITS-1:0]   open_sidx_reg, open_sidx_next;
    logic                    open_reg, open_next;
    logic [COUNT_BITS-1:0]   pic_reg, pic_next;
    logic [COUNT_BITS-1:0]   sync_reg, sync_next;
    logic [LEN_BITS-1:0]     sps_len_reg, sps_len_next;
    logic [LEN_BITS-1:0]     pps_len_reg, pps_len_next;
    logic [PROFILE_BITS-1:0] profile_reg, profile_next;
    logic [STATUS_BITS-1:0]  err_reg, err_next;
    logic [CAP_BITS-1:0]     cap_reg, cap_next;
    anx_push_t               push_int;

    always_comb
    begin : step
        logic [TYPE_BITS-1:0]   t;
        logic [OFFSET_BITS-1:0] off;
        logic [OFFSET_BITS-1:0] size;
        anx_result_t            r0;
        anx_result_t            r1;
        anx_result_t            rec;
        logic [1:0]             n;

        match_next     = match_reg;
        pos_next       = pos_reg;
        open_off_next  = open_off_reg;
        open_type_next = open_type_reg;
        open_sidx_next = open_sidx_reg;
        open_next      = open_reg;
        pic_next       = pic_reg;
        sync_next      = sync_reg;
        sps_len_next   = sps_len_reg;
        pps_len_next   = pps_len_reg;
        profile_next   = profile_reg;
        err_next       = err_reg;
        cap_next       = cap_reg;
        t    = data_byte[TYPE_BITS-1:0];
        off  = pos_reg - OFFSET_BITS'(SC_LEN);
        size = '0;
        r0   = '0;
        r1   = '0;
        rec  = '0;
        n    = 2'd0;

        if (err_reg == ST_OK)
        begin
            // sps bytes 1..3, most significant first
            case (cap_reg)
                2'd3:    profile_next[23:16] = data_byte;
                2'd2:    profile_next[15:8]  = data_byte;
                2'd1:    profile_next[7:0]   = data_byte;
                default: ;
            endcase
            if (cap_reg != '0)
            begin
                cap_next = cap_reg - 2'd1;
            end

            if (match_reg >= SC_LEN)
            begin
                // header byte: never starts a new match
                match_next = '0;
                if (open_reg)
                begin
                    size = off - open_off_reg - OFFSET_BITS'(SC_LEN);
                    if (open_type_reg == NAL_SPS)
                    begin
                        sps_len_next = sat_len(size);
                    end
                    else if (open_type_reg == NAL_PPS)
                    begin
                        pps_len_next = sat_len(size);
                    end
                    r0.nal_offset   = open_off_reg;
                    r0.nal_size     = size;
                    r0.nal_kind     = open_type_reg;
                    r0.sample_index = open_sidx_reg;
                    r0.record_valid = 1'b1;
                    n               = 2'd1;
                    open_next       = 1'b0;
                end
                if (t == NAL_SPS && sps_len_next != '0)
                begin
                    err_next = ST_DUP_SPS;
                end
                else if (t == NAL_PPS && pps_len_next != '0)
                begin
                    err_next = ST_DUP_PPS;
                end
                else
                begin
                    open_next      = 1'b1;
                    open_off_next  = off;
                    open_type_next = t;
                    if (t == NAL_SPS || t == NAL_PPS)
                    begin
                        open_sidx_next = '0;
                        if (t == NAL_SPS)
                        begin
                            profile_next = '0;
                            cap_next     = SPS_CAPTURE_BYTES;
                        end
                    end
                    else
                    begin
                        open_sidx_next = pic_reg;
                        pic_next       = pic_reg + 1'b1;
                        if (t == NAL_IDR)
                        begin
                            sync_next = sync_reg + 1'b1;
                        end
                    end
                end
            end
            else if (match_reg == SC_LEN - 3'd1)
            begin
                // long zero runs hold the match
                if (data_byte == 8'd1)
                begin
                    match_next = SC_LEN;
                end
                else if (data_byte != 8'd0)
                begin
                    match_next = '0;
                end
            end
            else
            begin
                match_next = (data_byte == 8'd0) ? match_reg + 3'd1 : '0;
            end
            pos_next = pos_reg + 1'b1;
        end

        if (end_of_stream)
        begin
            if (open_next)
            begin
                size = pos_next - open_off_next - OFFSET_BITS'(SC_LEN);
                if (open_type_next == NAL_SPS)
                begin
                    sps_len_next = sat_len(size);
                end
                else if (open_type_next == NAL_PPS)
                begin
                    pps_len_next = sat_len(size);
                end
                rec.nal_offset   = open_off_next;
                rec.nal_size     = size;
                rec.nal_kind     = open_type_next;
                rec.sample_index = open_sidx_next;
                rec.record_valid = 1'b1;
                open_next        = 1'b0;
            end
            if (n == 2'd0)
            begin
                r0 = rec;
            end
            else
            begin
                r1 = rec;
            end
            n = n + 2'd1;
            if (err_next == ST_OK && (sps_len_next == '0 || pps_len_next == '0))
            begin
                err_next = ST_MISSING;
            end
        end

        // summary snapshot after the whole item
        r0.status        = err_next;
        r0.picture_count = pic_next;
        r0.sync_count    = sync_next;
        r0.sps_size      = sps_len_next;
        r0.pps_size      = pps_len_next;
        r0.profile_level = profile_next;
        r0.last          = end_of_stream && (n == 2'd1);
        r1.status        = err_next;
        r1.picture_count = pic_next;
        r1.sync_count    = sync_next;
        r1.sps_size      = sps_len_next;
        r1.pps_size      = pps_len_next;
        r1.profile_level = profile_next;
        r1.last          = end_of_stream;

        push_int.count  = accept ? n : 2'd0;
        push_int.first  = r0;
        push_int.second = r1;

        // fresh stream after the final byte
        if (end_of_stream)
        begin
            match_next     = '0;
            pos_next       = '0;
            open_off_next  = '0;
            open_type_next = '0;
            open_sidx_next = '0;
            open_next      = 1'b0;
            pic_next       = '0;
            sync_next      = '0;
            sps_len_next   = '0;
            pps_len_next   = '0;
            profile_next   = '0;
            err_next       = ST_OK;
            cap_next       = '0;
        end
    end

    assign push = push_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= '0;
            pos_reg       <= '0;
            open_off_reg  <= '0;
            open_type_reg <= '0;
            open_sidx_reg <= '0;
            open_reg      <= 1'b0;
            pic_reg       <= '0;
            sync_reg      <= '0;
            sps_len_reg   <= '0;
            pps_len_reg   <= '0;
            profile_reg   <= '0;
            err_reg       <= ST_OK;
            cap_reg       <= '0;
        end
        else if (accept)
        begin
            match_reg     <= match_next;
            pos_reg       <= pos_next;
            open_off_reg  <= open_off_next;
            open_type_reg <= open_type_next;
            open_sidx_reg <= open_sidx_next;
            open_reg      <= open_next;
            pic_reg       <= pic_next;
            sync_reg      <= sync_next;
            sps_len_reg   <= sps_len_next;
            pps_len_reg   <= pps_len_next;
            profile_reg   <= profile_next;
            err_reg       <= err_next;
            cap_reg       <= cap_next;
        end
    end

    // two results only from the final byte of a stream
    a_two_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        push_int.count == 2'd2 |-> end_of_stream)
        else $error("two results from an item that does not end the stream");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_stream |=> pos_reg == '0 && !open_reg && err_reg == ST_OK)
        else $error("state not cleared after end of stream");

    a_error_closed: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK |-> !open_reg)
        else $error("unit left open after an error");

    a_match_range: assert property (@(posedge clk) disable iff (!rst_n)
        match_reg <= SC_LEN)
        else $error("start code match index out of range");

endmodule

// File: sv/anx_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anx_result_queue
// short shifting queue of result items; takes up to two per cycle and
// hands out the head item from a register
// ----------------------------------------------------------------------------
module anx_result_queue
    import anx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  anx_push_t   push,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output anx_result_t out_item
);

    anx_result_t           q_reg  [QUEUE_DEPTH];
    anx_result_t           q_next [QUEUE_DEPTH];
    logic [QCNT_BITS-1:0]  count_reg, count_next;
    logic [QCNT_BITS-1:0]  base;
    logic                  pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_item  = q_reg[0];
    // space for the worst case of two results from the next item
    assign room      = (count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));

    always_comb
    begin
        base       = count_reg - QCNT_BITS'(pop);
        count_next = base + QCNT_BITS'(push.count);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && i < QUEUE_DEPTH - 1)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push.count != 2'd0 && QCNT_BITS'(i) == base)
            begin
                q_next[i] = push.first;
            end
            if (push.count == 2'd2 && QCNT_BITS'(i) == base + 1'b1)
            begin
                q_next[i] = push.second;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2))
        else $error("results pushed without room");

endmodule

// File: sv/annexb_nal_unit_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_scanner
// finds 00 00 00 01 start codes in an annex b byte stream and emits one
// record per finished nal unit with a running stream summary
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   accepted when
//  s_axis    in   tdata[7:0] byte, tlast end of stream      s_tvalid & s_tready
//  m_axis    out  tdata record + summary, tuser record_valid,
//                 tlast final result of stream              m_tvalid & m_tready
//
// one byte is accepted per cycle; the state update is a single pass of
// compare and counter logic between the state registers and the result queue.
// a byte yields zero, one or two result items; the queue holds three, so
// input stalls only while more than one result waits on the output side.
// results go into the queue register and reach m_axis behind earlier ones.
// rst_n clears all stream state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module annexb_nal_unit_scanner
    import anx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,   // end_of_stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // nal_offset[31:0], nal_size[63:32], nal_kind[68:64], sample_index[100:69],
    // status[102:101], picture_count[134:103], sync_count[166:135],
    // sps_size[182:167], pps_size[198:183], profile_level[222:199], zero pad
    output logic [223:0] m_tdata,
    output logic         m_tuser,   // record_valid
    output logic         m_tlast    // last
);

    anx_push_t   push;
    anx_result_t head;
    logic        room;
    logic        accept;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    anx_scan_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_tdata),
        .end_of_stream (s_tlast),
        .push          (push)
    );

    anx_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = {1'b0, head.profile_level, head.pps_size, head.sps_size,
                      head.sync_count, head.picture_count, head.status,
                      head.sample_index, head.nal_kind, head.nal_size, head.nal_offset};
    assign m_tuser = head.record_valid;
    assign m_tlast = head.last;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream test of annexb_nal_unit_scanner. An initial block queues
// streams of bytes: a hand-built stream, a one-byte stream, then random
// streams. Most random streams are well-formed (parameter sets, then
// pictures). The rest are noise, duplicate parameter sets, missing parameter
// sets, and streams cut off inside a start code. A clocked driver sends the
// bytes, and a predictor works out the nal records due for each byte taken.
// A clocked monitor checks every record against them, field by field.
// ----------------------------------------------------------------------------
module testbench;
    import anx_pkg::*;

    localparam logic [TYPE_BITS-1:0] NAL_SLICE = 5'd1;
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;
    localparam logic [LEN_BITS-1:0] LEN_SAT = {LEN_BITS{1'b1}};

    localparam int RANDOM_ITEMS  = 1150;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;

    // hand-built stream: leading junk, long zero run, short sps, pps, a zero header
    // followed by 00 00 01, then an idr header as the last byte
    localparam int INTRO_LEN = 27;
    localparam logic [INTRO_LEN*8-1:0] INTRO = {
        8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h4D, 8'h40,
        8'h00, 8'h00, 8'h00, 8'h01, 8'h68, 8'h00, 8'h00, 8'h00, 8'h01,
        8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'hE5};

    typedef struct packed {
        logic       hold_for_drain;
        logic       eos;
        logic [7:0] data;
    } feed_item_t;

    logic         clk;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [223:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    feed_item_t  byte_feed[$];
    anx_result_t nal_records_due[$];

    int bytes_taken = 0;
    int feed_total = 0;
    int fed_counted = 0;
    int streams_fed = 0;
    bit skip_count = 1'b0;
    bit drain_next = 1'b0;
    int results_seen = 0;
    int error_count = 0;
    int unit_records = 0;
    int bare_records = 0;
    int streams_scanned = 0;
    int ending_status [4];
    logic [LEN_BITS-1:0] peak_len = '0;

    // predictor state
    logic [MATCH_BITS-1:0]   scan_match;
    logic [OFFSET_BITS-1:0]  scan_pos;
    logic [OFFSET_BITS-1:0]  unit_off;
    logic [TYPE_BITS-1:0]    unit_type;
    logic [COUNT_BITS-1:0]   unit_pic;
    logic                    unit_open;
    logic [COUNT_BITS-1:0]   pic_total;
    logic [COUNT_BITS-1:0]   idr_total;
    logic [LEN_BITS-1:0]     sps_len;
    logic [LEN_BITS-1:0]     pps_len;
    logic [PROFILE_BITS-1:0] sps_profile;
    logic [STATUS_BITS-1:0]  scan_status;
    int                      capture_left;

    annexb_nal_unit_scanner DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic clear_scan_state();
        scan_match   = '0;
        scan_pos     = '0;
        unit_off     = '0;
        unit_type    = '0;
        unit_pic     = '0;
        unit_open    = 1'b0;
        pic_total    = '0;
        idr_total    = '0;
        sps_len      = '0;
        pps_len      = '0;
        sps_profile  = '0;
        scan_status  = ST_OK;
        capture_left = 0;
    endtask

    function automatic anx_result_t close_unit(input logic [OFFSET_BITS-1:0] end_pos);
        anx_result_t r;
        logic [OFFSET_BITS-1:0] size;
        r = '0;
        size = end_pos - unit_off - OFFSET_BITS'(SC_LEN);
        if (unit_type == NAL_SPS)
        begin
            sps_len = (size > OFFSET_BITS'(LEN_SAT)) ? LEN_SAT : size[LEN_BITS-1:0];
        end
        else if (unit_type == NAL_PPS)
        begin
            pps_len = (size > OFFSET_BITS'(LEN_SAT)) ? LEN_SAT : size[LEN_BITS-1:0];
        end
        r.nal_offset   = unit_off;
        r.nal_size     = size;
        r.nal_kind     = unit_type;
        r.sample_index = unit_pic;
        r.record_valid = 1'b1;
        unit_open = 1'b0;
        return r;
    endfunction

    // one byte through the scanner; queues the records it finishes
    task automatic scan_byte(input logic [7:0] b, input logic eos);
        anx_result_t rec_a;
        anx_result_t rec_b;
        anx_result_t r;
        logic [TYPE_BITS-1:0] t;
        logic [OFFSET_BITS-1:0] start;
        int n;
        n = 0;
        rec_a = '0;
        rec_b = '0;
        if (scan_status == ST_OK)
        begin
            if (capture_left > 0)
            begin
                sps_profile = sps_profile | (PROFILE_BITS'(b) << (8 * (capture_left - 1)));
                capture_left--;
            end
            if (scan_match >= SC_LEN)
            begin
                t = b[TYPE_BITS-1:0];
                start = scan_pos - OFFSET_BITS'(SC_LEN);
                scan_match = '0;
                if (unit_open)
                begin
                    rec_a = close_unit(start);
                    n = 1;
                end
                if (t == NAL_SPS && sps_len != '0)
                begin
                    scan_status = ST_DUP_SPS;
                end
                else if (t == NAL_PPS && pps_len != '0)
                begin
                    scan_status = ST_DUP_PPS;
                end
                else
                begin
                    unit_open = 1'b1;
                    unit_off  = start;
                    unit_type = t;
                    if (t == NAL_SPS || t == NAL_PPS)
                    begin
                        unit_pic = '0;
                        if (t == NAL_SPS)
                        begin
                            sps_profile  = '0;
                            capture_left = 3;
                        end
                    end
                    else
                    begin
                        unit_pic  = pic_total;
                        pic_total = pic_total + 1'b1;
                        if (t == NAL_IDR)
                        begin
                            idr_total = idr_total + 1'b1;
                        end
                    end
                end
            end
            else if (scan_match == SC_LEN - 1'b1)
            begin
                if (b == SC_ONE)
                begin
                    scan_match = SC_LEN;
                end
                else if (b != SC_ZERO)
                begin
                    scan_match = '0;
                end
            end
            else
            begin
                scan_match = (b == SC_ZERO) ? scan_match + 1'b1 : '0;
            end
            scan_pos = scan_pos + 1'b1;
        end
        if (eos)
        begin
            r = unit_open ? close_unit(scan_pos) : '0;
            if (n == 0)
            begin
                rec_a = r;
            end
            else
            begin
                rec_b = r;
            end
            n++;
            if (scan_status == ST_OK && (sps_len == '0 || pps_len == '0))
            begin
                scan_status = ST_MISSING;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            r = (k == 0) ? rec_a : rec_b;
            r.status        = scan_status;
            r.picture_count = pic_total;
            r.sync_count    = idr_total;
            r.sps_size      = sps_len;
            r.pps_size      = pps_len;
            r.profile_level = sps_profile;
            r.last          = eos && (k == n - 1);
            if (r.record_valid)
            begin
                unit_records++;
            end
            else
            begin
                bare_records++;
            end
            nal_records_due.push_back(r);
        end
        if (eos)
        begin
            streams_scanned++;
            ending_status[scan_status]++;
            if (sps_len > peak_len)
            begin
                peak_len = sps_len;
            end
            clear_scan_state();
        end
    endtask

    task automatic feed_byte(input logic [7:0] b);
        feed_item_t it;
        it.hold_for_drain = drain_next;
        it.eos = 1'b0;
        it.data = b;
        drain_next = 1'b0;
        byte_feed.push_back(it);
        if (!skip_count)
        begin
            fed_counted++;
        end
    endtask

    task automatic end_stream();
        feed_item_t it;
        it = byte_feed[byte_feed.size() - 1];
        it.eos = 1'b1;
        byte_feed[byte_feed.size() - 1] = it;
        skip_count = 1'b0;
        streams_fed++;
    endtask

    task automatic feed_start_code(input int zeros);
        for (int k = 0; k < zeros; k++)
        begin
            feed_byte(SC_ZERO);
        end
        feed_byte(SC_ONE);
    endtask

    // zeros and ones are common so that partial start codes turn up in payload
    function automatic logic [7:0] payload_byte();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            b = SC_ZERO;
        end
        else if (pick < 30)
        begin
            b = SC_ONE;
        end
        else
        begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    task automatic feed_unit(input logic [TYPE_BITS-1:0] t);
        int body;
        feed_start_code(($urandom_range(99) < 20) ? $urandom_range(4, 6) : 3);
        feed_byte({3'($urandom_range(7)), t});
        body = ($urandom_range(99) < 10) ? $urandom_range(10, 40) : $urandom_range(0, 8);
        for (int k = 0; k < body; k++)
        begin
            feed_byte(payload_byte());
        end
    endtask

    task automatic gen_stream(input bit drain);
        int pick;
        int count;
        logic [TYPE_BITS-1:0] first_ps;
        logic [TYPE_BITS-1:0] t;
        drain_next = drain;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            count = $urandom_range(1, 12);
            for (int k = 0; k < count; k++)
            begin
                feed_byte(payload_byte());
            end
        end
        else
        begin
            count = $urandom_range(0, 2);
            for (int k = 0; k < count; k++)
            begin
                feed_byte(8'($urandom_range(255)));
            end
            first_ps = ($urandom_range(99) < 15) ? NAL_PPS : NAL_SPS;
            if ($urandom_range(99) < 90)
            begin
                feed_unit(first_ps);
            end
            if ($urandom_range(99) < 90)
            begin
                feed_unit((first_ps == NAL_SPS) ? NAL_PPS : NAL_SPS);
            end
            count = $urandom_range(0, 6);
            for (int k = 0; k < count; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    t = NAL_IDR;
                end
                else if (pick < 70)
                begin
                    t = NAL_SLICE;
                end
                else
                begin
                    t = TYPE_BITS'($urandom_range(31));
                    if (t == NAL_SPS || t == NAL_PPS)
                    begin
                        t = NAL_SLICE;
                    end
                end
                feed_unit(t);
            end
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                // repeated parameter set; what follows is dropped until the end
                feed_unit((pick < 6) ? NAL_SPS : NAL_PPS);
                skip_count = 1'b1;
                feed_unit(NAL_IDR);
            end
            if ($urandom_range(99) < 10)
            begin
                count = $urandom_range(1, 3);
                for (int k = 0; k < count; k++)
                begin
                    feed_byte(SC_ZERO);
                end
            end
        end
        end_stream();
    endtask

    function automatic string show_record(input anx_result_t r);
        return $sformatf("off=%0d size=%0d type=%0d idx=%0d st=%0d pics=%0d idr=%0d %s",
            r.nal_offset, r.nal_size, r.nal_kind, r.sample_index, r.status,
            r.picture_count, r.sync_count,
            $sformatf("sps=%0d pps=%0d prof=%06h valid=%0b last=%0b", r.sps_size,
                r.pps_size, r.profile_level, r.record_valid, r.last));
    endfunction

    function automatic string field_diff(input anx_result_t w, input anx_result_t g);
        string s;
        s = "";
        if (w.nal_offset !== g.nal_offset) s = {s, " nal_offset"};
        if (w.nal_size !== g.nal_size) s = {s, " nal_size"};
        if (w.nal_kind !== g.nal_kind) s = {s, " nal_kind"};
        if (w.sample_index !== g.sample_index) s = {s, " sample_index"};
        if (w.status !== g.status) s = {s, " status"};
        if (w.picture_count !== g.picture_count) s = {s, " picture_count"};
        if (w.sync_count !== g.sync_count) s = {s, " sync_count"};
        if (w.sps_size !== g.sps_size) s = {s, " sps_size"};
        if (w.pps_size !== g.pps_size) s = {s, " pps_size"};
        if (w.profile_level !== g.profile_level) s = {s, " profile_level"};
        if (w.record_valid !== g.record_valid) s = {s, " record_valid"};
        if (w.last !== g.last) s = {s, " last"};
        return s;
    endfunction

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        feed_item_t head;
        bit calm;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                calm = (bytes_taken >= 400 && bytes_taken < 900);
                if (byte_feed.size() != 0)
                begin
                    head = byte_feed[0];
                end
                else
                begin
                    head = '0;
                end
                if (byte_feed.size() != 0
                    && !(head.hold_for_drain && nal_records_due.size() != 0)
                    && (calm || $urandom_range(99) >= 13))
                begin
                    head = byte_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= head.data;
                    s_tlast  <= head.eos;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // record monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_records
        anx_result_t got;
        anx_result_t want;
        string bad;
        bit held_once;
        int hold_left;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            held_once = 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.nal_offset    = m_tdata[31:0];
                got.nal_size      = m_tdata[63:32];
                got.nal_kind      = m_tdata[68:64];
                got.sample_index  = m_tdata[100:69];
                got.status        = m_tdata[102:101];
                got.picture_count = m_tdata[134:103];
                got.sync_count    = m_tdata[166:135];
                got.sps_size      = m_tdata[182:167];
                got.pps_size      = m_tdata[198:183];
                got.profile_level = m_tdata[222:199];
                got.record_valid  = m_tuser;
                got.last          = m_tlast;
                results_seen++;
                if (nal_records_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("record %0d not expected: %s", results_seen, show_record(got));
                    end
                end
                else
                begin
                    want = nal_records_due.pop_front();
                    bad = field_diff(want, got);
                    if (bad != "")
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("record %0d wrong in%s", results_seen, bad);
                            $display("  expected %s", show_record(want));
                            $display("  actual   %s", show_record(got));
                        end
                    end
                end
            end
            // one long hold-off so the scanner backs up and stalls its input
            if (!held_once && results_seen >= 30)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= (results_seen >= 60 && results_seen < 160)
                            || ($urandom_range(99) >= 13);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        for (int k = 0; k < 4; k++)
        begin
            ending_status[k] = 0;
        end
        clear_scan_state();

        for (int k = INTRO_LEN - 1; k >= 0; k--)
        begin
            feed_byte(INTRO[8*k +: 8]);
        end
        end_stream();
        // a lone byte: no unit at all, so a bare summary reporting missing sets
        feed_byte(8'h7F);
        end_stream();

        while (fed_counted < RANDOM_ITEMS)
        begin
            gen_stream((streams_fed % 9) == 4);
        end
        feed_total = byte_feed.size();

        while (bytes_taken != feed_total || nal_records_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("scanned %0d bytes in %0d streams; %0d nal records and %0d bare summaries",
            bytes_taken, streams_scanned, unit_records, bare_records);
        $display("stream endings ok/dup sps/dup pps/missing: %0d/%0d/%0d/%0d, peak sps length %0d",
            ending_status[ST_OK], ending_status[ST_DUP_SPS], ending_status[ST_DUP_PPS],
            ending_status[ST_MISSING], peak_len);
        if (error_count == 0 && nal_records_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
